FILE: rtl/core/bgms_pkg.sv
// Shared constants and types for the binary grid majority smoothing block.
package bgms_pkg;

  // Number of grid columns (legal range 3 to 64).
  localparam int GridWidth = 32;
  // Width of the row ports.
  localparam int RowWidth  = 32;
  // Width of the tie register.
  localparam int TieWidth  = 4;
  localparam logic [TieWidth-1:0] TieReset = TieWidth'(4);

  // Bits one column cell shows to its neighbors.
  typedef struct packed {
    logic above;
    logic pending;
    logic row;
  } nbr_t;

  // Row-level control broadcast to every cell.
  typedef struct packed {
    logic shift;     // accept a row that is not the last one
    logic clear;     // accept the last row, return to reset contents
    logic pend_vld;  // a row is waiting for its lower neighbor
  } cell_ctl_t;

endpackage

FILE: rtl/core/bgms_cell.sv
// One column cell: holds the above and pending bits of its column and smooths them.
module bgms_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bgms_pkg::cell_ctl_t               ctl_i,
  input  logic                              row_bit_i,
  input  bgms_pkg::nbr_t                    left_i,
  input  bgms_pkg::nbr_t                    right_i,
  input  logic [bgms_pkg::TieWidth-1:0]     tie_i,
  output bgms_pkg::nbr_t                    self_o,
  output logic                              res0_o,
  output logic                              res1_o
);

  logic above_q, above_d;
  logic pending_q, pending_d;
  logic up2_l, up2_c, up2_r;

  // 8-neighbor wall count against the tie value.
  function automatic logic smooth_bit(input logic [7:0] nbrs, input logic mid,
                                      input logic [bgms_pkg::TieWidth-1:0] tie);
    logic [bgms_pkg::TieWidth-1:0] n;
    logic                          b;
    n = '0;
    for (int k = 0; k < 8; k++) begin
      n = n + {{(bgms_pkg::TieWidth-1){1'b0}}, nbrs[k]};
    end
    if (n > tie) begin
      b = 1'b1;
    end else if (n < tie) begin
      b = 1'b0;
    end else begin
      b = mid;
    end
    return b;
  endfunction

  assign self_o = '{above: above_q, pending: pending_q, row: row_bit_i};

  // Second result looks at walls above when nothing is pending (one-row grid).
  assign up2_l = left_i.pending  | ~ctl_i.pend_vld;
  assign up2_c = pending_q       | ~ctl_i.pend_vld;
  assign up2_r = right_i.pending | ~ctl_i.pend_vld;

  always_comb begin
    res0_o = smooth_bit({left_i.above, above_q, right_i.above,
                         left_i.pending, right_i.pending,
                         left_i.row, row_bit_i, right_i.row},
                        pending_q, tie_i);
    res1_o = smooth_bit({up2_l, up2_c, up2_r,
                         left_i.row, right_i.row,
                         3'b111},
                        row_bit_i, tie_i);
  end

  always_comb begin
    above_d   = above_q;
    pending_d = pending_q;
    if (ctl_i.clear) begin
      above_d   = 1'b1;
      pending_d = 1'b0;
    end else if (ctl_i.shift) begin
      above_d   = pending_q | ~ctl_i.pend_vld;
      pending_d = row_bit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q   <= 1'b1;
      pending_q <= 1'b0;
    end else begin
      above_q   <= above_d;
      pending_q <= pending_d;
    end
  end

endmodule

FILE: rtl/core/binary_grid_majority_smoothing.sv
// Top level: row-streaming 4-5 rule cave smoothing over a row of column cells.
// Timing: a result enters the output queue at the edge that accepts the row that
//   completes it, behind any older results; output lags input by one row.
// Throughput: one row per cycle unless stalled, set by the column cells that smooth a
//   full row each cycle; a grid's last row yields two results, held by a 4-entry queue.
// Reset: asynchronous, active low; tie count returns to 4, no row pending, queue empty.
module binary_grid_majority_smoothing (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // row input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bgms_pkg::RowWidth-1:0]     row_cells_i,
  input  logic                              last_row_i,
  // smoothed row channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bgms_pkg::RowWidth-1:0]     smoothed_row_o,
  output logic                              last_out_o,
  // tie count write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bgms_pkg::TieWidth-1:0]     tie_count_i
);

  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  // ---------------------------------------------------------------------------
  // Tie count register, written whenever a request arrives.
  // ---------------------------------------------------------------------------
  logic [bgms_pkg::TieWidth-1:0] tie_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tie_q <= bgms_pkg::TieReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tie_q <= tie_count_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Row control. pend_vld_q says the cells hold a row still waiting for the
  // row below it.
  // ---------------------------------------------------------------------------
  logic                  in_acc;
  logic                  pend_vld_q, pend_vld_d;
  bgms_pkg::cell_ctl_t   ctl;

  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;

  // Keep room for the two results of a last row.
  assign in_stall_o = cnt_q > CntW'(FifoDepth - 2);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign ctl = '{shift:    in_acc && !last_row_i,
                 clear:    in_acc &&  last_row_i,
                 pend_vld: pend_vld_q};

  always_comb begin
    pend_vld_d = pend_vld_q;
    if (in_acc) begin
      pend_vld_d = !last_row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Column cells. Each one sees its left and right neighbor; columns outside
  // the grid read as wall. Columns above the port width read as floor.
  // ---------------------------------------------------------------------------
  bgms_pkg::nbr_t                   self_s [bgms_pkg::GridWidth];
  logic [bgms_pkg::GridWidth-1:0]   res0_s;
  logic [bgms_pkg::GridWidth-1:0]   res1_s;
  logic [bgms_pkg::GridWidth-1:0]   above_s;
  logic [bgms_pkg::RowWidth-1:0]    res0_row;
  logic [bgms_pkg::RowWidth-1:0]    res1_row;

  for (genvar c = 0; c < bgms_pkg::GridWidth; c++) begin : g_col
    logic           row_bit;
    bgms_pkg::nbr_t left_n;
    bgms_pkg::nbr_t right_n;

    if (c < bgms_pkg::RowWidth) begin : g_in
      assign row_bit = row_cells_i[c];
    end else begin : g_pad
      assign row_bit = 1'b0;
    end

    if (c == 0) begin : g_ledge
      assign left_n = '1;
    end else begin : g_lnbr
      assign left_n = self_s[c-1];
    end

    if (c == bgms_pkg::GridWidth - 1) begin : g_redge
      assign right_n = '1;
    end else begin : g_rnbr
      assign right_n = self_s[c+1];
    end

    bgms_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .row_bit_i (row_bit),
      .left_i    (left_n),
      .right_i   (right_n),
      .tie_i     (tie_q),
      .self_o    (self_s[c]),
      .res0_o    (res0_s[c]),
      .res1_o    (res1_s[c])
    );

    assign above_s[c] = self_s[c].above;
  end

  // Fit grid results to the port width; columns past the grid are zero.
  for (genvar b = 0; b < bgms_pkg::RowWidth; b++) begin : g_out
    if (b < bgms_pkg::GridWidth) begin : g_bit
      assign res0_row[b] = res0_s[b];
      assign res1_row[b] = res1_s[b];
    end else begin : g_zero
      assign res0_row[b] = 1'b0;
      assign res1_row[b] = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue. A row with a pending row above it produces the pending
  // row's result; a last row also produces its own. A last row with nothing
  // pending is a one-row grid and produces only its own.
  // ---------------------------------------------------------------------------
  logic [bgms_pkg::RowWidth-1:0] q_row_q  [FifoDepth];
  logic                          q_last_q [FifoDepth];
  logic                          push0, push1, pop;
  logic [bgms_pkg::RowWidth-1:0] push0_row;
  logic                          push0_last;
  logic [PtrW-1:0]               wr_ptr_nxt;

  assign push0      = in_acc && (pend_vld_q || last_row_i);
  assign push1      = in_acc && pend_vld_q && last_row_i;
  assign push0_row  = pend_vld_q ? res0_row : res1_row;
  assign push0_last = !pend_vld_q;
  assign pop        = out_valid_o && !out_stall_i;
  assign wr_ptr_nxt = wr_ptr_q + PtrW'(1);

  always_comb begin
    cnt_d    = cnt_q + CntW'(push0) + CntW'(push1) - CntW'(pop);
    wr_ptr_d = wr_ptr_q + PtrW'(push0) + PtrW'(push1);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      cnt_q    <= cnt_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0) begin
      q_row_q[wr_ptr_q]  <= push0_row;
      q_last_q[wr_ptr_q] <= push0_last;
    end
    if (push1) begin
      q_row_q[wr_ptr_nxt]  <= res1_row;
      q_last_q[wr_ptr_nxt] <= 1'b1;
    end
  end

  assign out_valid_o    = cnt_q != '0;
  assign smoothed_row_o = q_row_q[rd_ptr_q];
  assign last_out_o     = q_last_q[rd_ptr_q];

`ifndef SYNTHESIS
  // Queue never holds more than its depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("output queue overfilled");

  // With nothing pending, every cell holds walls as the row above.
  a_above_walls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_vld_q |-> (&above_s))
    else $error("row above not all walls while idle");

  // A last row ends the grid; any other row leaves one pending.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_row_i |=> !pend_vld_q)
    else $error("pending row survived last row");

  a_row_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !last_row_i |=> pend_vld_q)
    else $error("accepted row not pending");
`endif

endmodule
